@@ src/opp_pkg.sv @@
// Package for the operator-precedence expression parser: codes, shared types,
// the precedence table and default sizes.
// Depends on nothing; the front end, queue, back end and top level refer to it by scoped names.
package opp_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int STACK_DEPTH_DEF = 32;
  localparam int HANDLE_BITS_DEF = 16;

  // At most this many records leave for one token, the status record included.
  localparam int MAX_RECORDS = 17;

  // Number of classified tokens held between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Token classes, also used as the kind of a stack entry.
  localparam logic [3:0] CLS_ADD    = 4'd0;
  localparam logic [3:0] CLS_MUL    = 4'd1;
  localparam logic [3:0] CLS_EQ     = 4'd2;
  localparam logic [3:0] CLS_REL    = 4'd3;
  localparam logic [3:0] CLS_LP     = 4'd4;
  localparam logic [3:0] CLS_RP     = 4'd5;
  localparam logic [3:0] CLS_ID     = 4'd6;
  localparam logic [3:0] CLS_SC     = 4'd7;
  localparam logic [3:0] CLS_LEXERR = 4'd8;
  localparam logic [3:0] CLS_SYSERR = 4'd9;

  // Stack entry kind of a nonterminal.
  localparam logic [3:0] KIND_E = 4'd8;

  // Operator codes.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LAST = 4'd10;
  localparam logic [3:0] OP_NOP  = 4'd11;

  // Status codes of the record that ends a token.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DONE_SC  = 3'd1;
  localparam logic [2:0] ST_DONE_RP  = 3'd2;
  localparam logic [2:0] ST_SYNTAX   = 3'd3;
  localparam logic [2:0] ST_LEX      = 3'd4;
  localparam logic [2:0] ST_INTERNAL = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  // Record kinds.
  localparam logic REC_INSTR  = 1'b0;
  localparam logic REC_STATUS = 1'b1;

  // Precedence relations.
  typedef enum logic [2:0] {
    ACT_LESS,
    ACT_MORE,
    ACT_MATCH,
    ACT_ERROR,
    ACT_FINISH
  } act_e;

  // A classified token as it travels through the queue. err is ST_OK for a
  // token that goes on to the stack engine.
  typedef struct packed {
    logic [2:0] err;
    logic [3:0] cls;
    logic [3:0] opc;
  } tok_ctl_t;

  // Tag part of a stack entry: its kind and the topmost terminal below it.
  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] prev;
  } stk_tag_t;

  // Rows: topmost terminal on the stack. Columns: class of the incoming token.
  localparam act_e PREC_TAB [0:7][0:7] = '{
    '{ACT_MORE, ACT_LESS, ACT_MORE, ACT_MORE, ACT_LESS, ACT_MORE, ACT_LESS, ACT_MORE},
    '{ACT_MORE, ACT_MORE, ACT_MORE, ACT_MORE, ACT_LESS, ACT_MORE, ACT_LESS, ACT_MORE},
    '{ACT_LESS, ACT_LESS, ACT_MORE, ACT_LESS, ACT_LESS, ACT_MORE, ACT_LESS, ACT_MORE},
    '{ACT_LESS, ACT_LESS, ACT_MORE, ACT_MORE, ACT_LESS, ACT_MORE, ACT_LESS, ACT_MORE},
    '{ACT_LESS, ACT_LESS, ACT_LESS, ACT_LESS, ACT_LESS, ACT_MATCH, ACT_LESS, ACT_ERROR},
    '{ACT_MORE, ACT_MORE, ACT_MORE, ACT_MORE, ACT_ERROR, ACT_MORE, ACT_ERROR, ACT_MORE},
    '{ACT_MORE, ACT_MORE, ACT_MORE, ACT_MORE, ACT_ERROR, ACT_MORE, ACT_ERROR, ACT_MORE},
    '{ACT_LESS, ACT_LESS, ACT_LESS, ACT_LESS, ACT_LESS, ACT_FINISH, ACT_LESS, ACT_ERROR}
  };

  function automatic act_e prec_lookup(input logic [2:0] top_term, input logic [2:0] tok_cls);
    return PREC_TAB[top_term][tok_cls];
  endfunction

endpackage

@@ src/opp_if.sv @@
// Channel interfaces of the operator-precedence expression parser: the token
// input channel and the record output channel, each with valid/ready.
// Depends on nothing.
interface opp_tok_if #(
  parameter int HANDLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_class;
  logic [3:0]             op_code;
  logic [HANDLE_BITS-1:0] operand_handle;

  modport source (output valid, output token_class, output op_code,
                  output operand_handle, input ready);
  modport sink (input valid, input token_class, input op_code,
                input operand_handle, output ready);
endinterface

interface opp_rec_if #(
  parameter int HANDLE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 record_kind;
  logic [3:0]           instr_op;
  logic [HANDLE_BITS:0] left_handle;
  logic [HANDLE_BITS:0] right_handle;
  logic [HANDLE_BITS:0] result_handle;
  logic [2:0]           status;
  logic                 last;

  modport source (output valid, output record_kind, output instr_op,
                  output left_handle, output right_handle, output result_handle,
                  output status, output last, input ready);
  modport sink (input valid, input record_kind, input instr_op,
                input left_handle, input right_handle, input result_handle,
                input status, input last, output ready);
endinterface

@@ src/opp_front.sv @@
// Front end of the parser: takes token beats and classifies them, settling
// the errors that need no stack, and hands them to the queue.
// Depends on opp_pkg and opp_tok_if.
module opp_front #(
  parameter int HANDLE_BITS = opp_pkg::HANDLE_BITS_DEF
) (
  opp_tok_if.sink                tok_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output opp_pkg::tok_ctl_t      q_ctl_o,
  output logic [HANDLE_BITS-1:0] q_handle_o
);

  logic is_oper;

  assign tok_i.ready = !q_full_i;
  assign q_push_o    = tok_i.valid && !q_full_i;
  assign q_handle_o  = tok_i.operand_handle;
  assign is_oper     = (tok_i.token_class <= opp_pkg::CLS_REL);

  always_comb begin
    q_ctl_o.cls = tok_i.token_class;
    q_ctl_o.opc = tok_i.op_code;
    priority if (tok_i.token_class == opp_pkg::CLS_LEXERR) begin
      q_ctl_o.err = opp_pkg::ST_LEX;
    end else if (tok_i.token_class == opp_pkg::CLS_SYSERR) begin
      q_ctl_o.err = opp_pkg::ST_INTERNAL;
    end else if (tok_i.token_class > opp_pkg::CLS_SYSERR) begin
      q_ctl_o.err = opp_pkg::ST_SYNTAX;
    end else if (is_oper && tok_i.op_code > opp_pkg::OP_LAST) begin
      // An operator class with an operator code that means nothing.
      q_ctl_o.err = opp_pkg::ST_SYNTAX;
    end else begin
      q_ctl_o.err = opp_pkg::ST_OK;
    end
  end

endmodule

@@ src/opp_queue.sv @@
// Short queue of classified tokens between the front and the back end.
// Depends on opp_pkg for its depth.
module opp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);

  localparam int Depth = opp_pkg::QUEUE_DEPTH;
  localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int NW    = $clog2(Depth + 1);

  logic [WIDTH-1:0] slot_q [Depth];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]    fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == NW'(Depth));
  assign empty_o = (fill_q == '0);
  assign head_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + PW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + NW'(1);
      2'b01:   fill_d = fill_q - NW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/opp_back.sv @@
// Back end of the parser: the stack engine with its stack memory, a window of
// the three top entries in registers, the temporary counter and the record register.
// Depends on opp_pkg and opp_rec_if.
module opp_back #(
  parameter int STACK_DEPTH = opp_pkg::STACK_DEPTH_DEF,
  parameter int HANDLE_BITS = opp_pkg::HANDLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  opp_pkg::tok_ctl_t      q_ctl_i,
  input  logic [HANDLE_BITS-1:0] q_handle_i,
  output logic                   q_pop_o,
  opp_rec_if.source              rec_o
);

  localparam int VW = HANDLE_BITS + 1;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int TW = $bits(opp_pkg::stk_tag_t);
  localparam int EW = TW + VW;
  localparam int KW = $clog2(opp_pkg::MAX_RECORDS);

  localparam logic [1:0] S_EVAL = 2'd0;
  localparam logic [1:0] S_LD1  = 2'd1;
  localparam logic [1:0] S_LD2  = 2'd2;

  localparam opp_pkg::stk_tag_t MARK_TAG = '{kind: opp_pkg::CLS_SC,
                                             prev: opp_pkg::CLS_SC[2:0]};

  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  opp_pkg::stk_tag_t     tag_q [0:2];
  opp_pkg::stk_tag_t     tag_d [0:2];
  logic [VW-1:0]         val_q [0:2];
  logic [VW-1:0]         val_d [0:2];
  logic [HANDLE_BITS-1:0] temp_q, temp_d;
  logic [KW-1:0]         kcnt_q, kcnt_d;

  logic [EW-1:0]         mem_q [STACK_DEPTH];
  logic [EW-1:0]         rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [EW-1:0]         mem_wdata;
  opp_pkg::stk_tag_t     rd_tag;
  logic [VW-1:0]         rd_val;

  logic                  out_valid_q, out_valid_d;
  logic                  rkind_q, rkind_d;
  logic [3:0]            rop_q, rop_d;
  logic [VW-1:0]         rleft_q, rleft_d, rright_q, rright_d, rres_q, rres_d;
  logic [2:0]            rstat_q, rstat_d;
  logic                  rlast_q, rlast_d;

  logic [2:0]            top_term;
  opp_pkg::act_e         act;
  logic [VW-1:0]         temp_handle, push_val;
  logic                  out_free;

  // Outcome of one evaluation step.
  logic                  fin, do_push, do_paren, do_ide, do_red;
  logic [2:0]            fst;
  logic [3:0]            fop;
  logic [VW-1:0]         fres;
  logic                  emit_red, emit_fin;

  assign top_term    = (tag_q[0].kind == opp_pkg::KIND_E) ? tag_q[0].prev
                                                          : tag_q[0].kind[2:0];
  assign act         = opp_pkg::prec_lookup(top_term, q_ctl_i.cls[2:0]);
  assign temp_handle = {1'b1, temp_q};
  assign out_free    = !out_valid_q || rec_o.ready;
  assign rd_tag      = opp_pkg::stk_tag_t'(rdata_q[EW-1 -: TW]);
  assign rd_val      = rdata_q[VW-1:0];

  always_comb begin
    if (q_ctl_i.cls <= opp_pkg::CLS_REL) begin
      push_val = VW'(q_ctl_i.opc);
    end else if (q_ctl_i.cls == opp_pkg::CLS_ID) begin
      push_val = {1'b0, q_handle_i};
    end else begin
      push_val = '0;
    end
  end

  // Decide what the token at the head of the queue does to the stack now.
  always_comb begin
    fin      = 1'b0;
    do_push  = 1'b0;
    do_paren = 1'b0;
    do_ide   = 1'b0;
    do_red   = 1'b0;
    fst      = opp_pkg::ST_OK;
    fop      = opp_pkg::OP_NONE;
    fres     = '0;
    priority if (q_ctl_i.err != opp_pkg::ST_OK) begin
      fin = 1'b1;
      fst = q_ctl_i.err;
    end else if (q_ctl_i.cls == opp_pkg::CLS_SC && top_term == opp_pkg::CLS_SC[2:0] &&
                 cnt_q > CW'(1)) begin
      fin  = 1'b1;
      fst  = opp_pkg::ST_DONE_SC;
      fop  = opp_pkg::OP_NOP;
      fres = val_q[0];
    end else begin
      unique case (act)
        opp_pkg::ACT_LESS: begin
          fin = 1'b1;
          if (cnt_q >= CW'(STACK_DEPTH)) begin
            fst = opp_pkg::ST_OVERFLOW;
          end else begin
            do_push = 1'b1;
          end
        end
        opp_pkg::ACT_MATCH: begin
          fin = 1'b1;
          if (cnt_q < CW'(3) || tag_q[0].kind != opp_pkg::KIND_E ||
              tag_q[1].kind != opp_pkg::CLS_LP) begin
            fst = opp_pkg::ST_SYNTAX;
          end else begin
            do_paren = 1'b1;
          end
        end
        opp_pkg::ACT_FINISH: begin
          fin  = 1'b1;
          fst  = opp_pkg::ST_DONE_RP;
          fop  = opp_pkg::OP_NOP;
          fres = (tag_q[0].kind == opp_pkg::KIND_E) ? val_q[0] : '0;
        end
        opp_pkg::ACT_MORE: begin
          priority if (tag_q[0].kind == opp_pkg::CLS_ID) begin
            do_ide = 1'b1;
          end else if (cnt_q < CW'(4) || tag_q[0].kind != opp_pkg::KIND_E ||
                       tag_q[1].kind > opp_pkg::CLS_REL ||
                       tag_q[2].kind != opp_pkg::KIND_E) begin
            fin = 1'b1;
            fst = opp_pkg::ST_SYNTAX;
          end else if (kcnt_q >= KW'(opp_pkg::MAX_RECORDS - 1)) begin
            fin = 1'b1;
            fst = opp_pkg::ST_INTERNAL;
          end else begin
            do_red = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
          fst = opp_pkg::ST_SYNTAX;
        end
      endcase
    end
  end

  assign emit_red = (state_q == S_EVAL) && !q_empty_i && do_red && out_free;
  assign emit_fin = (state_q == S_EVAL) && !q_empty_i && fin && out_free;
  assign q_pop_o  = emit_fin;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tag_d       = tag_q;
    val_d       = val_q;
    temp_d      = temp_q;
    kcnt_d      = kcnt_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    out_valid_d = rec_o.ready ? 1'b0 : out_valid_q;
    rkind_d     = rkind_q;
    rop_d       = rop_q;
    rleft_d     = rleft_q;
    rright_d    = rright_q;
    rres_d      = rres_q;
    rstat_d     = rstat_q;
    rlast_d     = rlast_q;

    unique case (state_q)
      S_EVAL: begin
        if (!q_empty_i && do_ide) begin
          // An operand on top becomes E in place; no record.
          tag_d[0].kind = opp_pkg::KIND_E;
          mem_we        = 1'b1;
          mem_waddr     = AW'(cnt_q - CW'(1));
          mem_wdata     = {opp_pkg::stk_tag_t'{kind: opp_pkg::KIND_E, prev: tag_q[0].prev},
                           val_q[0]};
        end else if (emit_red) begin
          out_valid_d = 1'b1;
          rkind_d     = opp_pkg::REC_INSTR;
          rop_d       = val_q[1][3:0];
          rleft_d     = val_q[2];
          rright_d    = val_q[0];
          rres_d      = temp_handle;
          rstat_d     = opp_pkg::ST_OK;
          rlast_d     = 1'b0;
          temp_d      = temp_q + HANDLE_BITS'(1);
          kcnt_d      = kcnt_q + KW'(1);
          cnt_d       = cnt_q - CW'(2);
          tag_d[0]    = '{kind: opp_pkg::KIND_E, prev: tag_q[2].prev};
          val_d[0]    = temp_handle;
          mem_we      = 1'b1;
          mem_waddr   = AW'(cnt_q - CW'(3));
          mem_wdata   = {opp_pkg::stk_tag_t'{kind: opp_pkg::KIND_E, prev: tag_q[2].prev},
                         temp_handle};
          mem_raddr   = AW'(cnt_q - CW'(4));
          state_d     = S_LD1;
        end else if (emit_fin) begin
          out_valid_d = 1'b1;
          rkind_d     = opp_pkg::REC_STATUS;
          rop_d       = fop;
          rleft_d     = '0;
          rright_d    = '0;
          rres_d      = fres;
          rstat_d     = fst;
          rlast_d     = 1'b1;
          kcnt_d      = '0;
          if (do_push) begin
            tag_d[2]  = tag_q[1];
            val_d[2]  = val_q[1];
            tag_d[1]  = tag_q[0];
            val_d[1]  = val_q[0];
            tag_d[0]  = '{kind: q_ctl_i.cls, prev: top_term};
            val_d[0]  = push_val;
            cnt_d     = cnt_q + CW'(1);
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_q);
            mem_wdata = {opp_pkg::stk_tag_t'{kind: q_ctl_i.cls, prev: top_term}, push_val};
          end else if (do_paren) begin
            // "( E" collapses into E holding the inner handle.
            tag_d[0]  = '{kind: opp_pkg::KIND_E, prev: tag_q[1].prev};
            val_d[0]  = val_q[0];
            tag_d[1]  = tag_q[2];
            val_d[1]  = val_q[2];
            cnt_d     = cnt_q - CW'(1);
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_q - CW'(2));
            mem_wdata = {opp_pkg::stk_tag_t'{kind: opp_pkg::KIND_E, prev: tag_q[1].prev},
                         val_q[0]};
            mem_raddr = AW'(cnt_q - CW'(4));
            state_d   = S_LD2;
          end else if (fst != opp_pkg::ST_OK) begin
            cnt_d    = CW'(1);
            tag_d[0] = MARK_TAG;
          end
        end
      end
      S_LD1: begin
        // Second window entry arrives; ask for the third.
        tag_d[1]  = (cnt_q == CW'(2)) ? MARK_TAG : rd_tag;
        val_d[1]  = (cnt_q == CW'(2)) ? '0 : rd_val;
        mem_raddr = AW'(cnt_q - CW'(3));
        state_d   = S_LD2;
      end
      S_LD2: begin
        tag_d[2] = (cnt_q == CW'(3)) ? MARK_TAG : rd_tag;
        val_d[2] = (cnt_q == CW'(3)) ? '0 : rd_val;
        state_d  = S_EVAL;
      end
      default: begin
        state_d = S_EVAL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_EVAL;
      cnt_q       <= CW'(1);
      tag_q       <= '{MARK_TAG, MARK_TAG, MARK_TAG};
      temp_q      <= '0;
      kcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tag_q       <= tag_d;
      temp_q      <= temp_d;
      kcnt_q      <= kcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    rkind_q  <= rkind_d;
    rop_q    <= rop_d;
    rleft_q  <= rleft_d;
    rright_q <= rright_d;
    rres_q   <= rres_d;
    rstat_q  <= rstat_d;
    rlast_q  <= rlast_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign rec_o.valid         = out_valid_q;
  assign rec_o.record_kind   = rkind_q;
  assign rec_o.instr_op      = rop_q;
  assign rec_o.left_handle   = rleft_q;
  assign rec_o.right_handle  = rright_q;
  assign rec_o.result_handle = rres_q;
  assign rec_o.status        = rstat_q;
  assign rec_o.last          = rlast_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q >= CW'(1) && cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count out of range");

  a_temp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_red |=> temp_q == HANDLE_BITS'($past(temp_q) + HANDLE_BITS'(1)))
    else $error("temporary counter did not advance with an instruction record");

  a_red_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_red |=> cnt_q == CW'($past(cnt_q) - CW'(2)) && state_q == S_LD1)
    else $error("reduction did not pop two entries and refill the window");

  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fin && fst != opp_pkg::ST_OK) |=>
      cnt_q == CW'(1) && tag_q[0].kind == opp_pkg::CLS_SC)
    else $error("ending status did not clear the stack to the end marker");
`endif

endmodule

@@ src/operator_precedence_expression_parser.sv @@
// Top level of the operator-precedence expression parser: front end, token
// queue and stack engine. Depends on opp_pkg, opp_if, opp_front, opp_queue, opp_back.
//
//   channel   direction   beat                                      handshake
//   tok_i     in          token_class, op_code, operand_handle      valid/ready
//   rec_o     out         record_kind, instr_op, left/right/result  valid/ready
//                         handle, status, last
//
// Flow: the front end queues a token in the cycle it is offered. The stack
// engine handles a shift, an ending status or turning an operand into E in
// its evaluation state; an "E op E" reduction goes on through S_LD1 and S_LD2,
// and a parenthesis match through S_LD2; these states refill the top-of-stack
// window through the single read port of the stack memory.
// Reset leaves the end marker alone on the stack and the temporary counter at
// zero; the stack memory itself needs no clearing pass.
// A stalled record register holds back reductions and ending statuses, while the queue keeps taking tokens until full.
module operator_precedence_expression_parser #(
  parameter int STACK_DEPTH = opp_pkg::STACK_DEPTH_DEF,
  parameter int HANDLE_BITS = opp_pkg::HANDLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  opp_tok_if.sink   tok_i,
  opp_rec_if.source rec_o
);

  // One queue slot carries the operand handle and the classified control part.
  localparam int QW = HANDLE_BITS + $bits(opp_pkg::tok_ctl_t);

  logic                   push;
  logic                   full;
  logic                   pop;
  logic                   empty;
  opp_pkg::tok_ctl_t      front_ctl;
  logic [HANDLE_BITS-1:0] front_handle;
  logic [QW-1:0]          head;
  opp_pkg::tok_ctl_t      head_ctl;
  logic [HANDLE_BITS-1:0] head_handle;

  // The front end settles the errors that do not depend on the stack, so the
  // engine only looks at err to end such a token at once.
  opp_front #(
    .HANDLE_BITS(HANDLE_BITS)
  ) u_front (
    .tok_i      (tok_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_ctl_o    (front_ctl),
    .q_handle_o (front_handle)
  );

  // The queue lets the source keep delivering tokens while the engine is
  // busy with reductions or waiting on the record sink.
  opp_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({front_handle, front_ctl}),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  assign head_handle = head[QW-1 -: HANDLE_BITS];
  assign head_ctl    = opp_pkg::tok_ctl_t'(head[$bits(opp_pkg::tok_ctl_t)-1:0]);

  // The engine pops a token from the queue only when it writes the status
  // beat that ends that token's run.
  opp_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (empty),
    .q_ctl_i    (head_ctl),
    .q_handle_i (head_handle),
    .q_pop_o    (pop),
    .rec_o      (rec_o)
  );

endmodule
